// File: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge while reset is released.
`define SDBM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition never holds at a rising clock edge while out of reset.
`define SDBM_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: design/sdbm_pkg.sv
package sdbm_pkg;

  localparam int unsigned HashW    = 64;
  localparam int unsigned CharW    = 8;
  localparam int unsigned BucketW  = 16;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);
  localparam int unsigned DivCntW    = $clog2(HashW);

  // Terminating byte of a key.
  localparam logic [CharW-1:0] KeyEnd = '0;

  typedef logic [HashW-1:0]   hash_t;
  typedef logic [BucketW-1:0] bucket_t;

  // Status of the hash queue between the front and back ends.
  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

endpackage

// File: design/sdbm_queue.sv
module sdbm_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  sdbm_pkg::hash_t     push_data_i,
  input  logic                pop_i,
  output sdbm_pkg::hash_t     pop_data_o,
  output sdbm_pkg::q_stat_t   stat_o
);

  sdbm_pkg::hash_t                     mem_q [sdbm_pkg::QueueDepth];
  logic [sdbm_pkg::QueuePtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [sdbm_pkg::QueuePtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [sdbm_pkg::QueueCntW-1:0]      cnt_q, cnt_d;
  logic                                do_push, do_pop;

  localparam logic [sdbm_pkg::QueuePtrW-1:0] LastPtr =
    sdbm_pkg::QueuePtrW'(sdbm_pkg::QueueDepth - 1);
  localparam logic [sdbm_pkg::QueueCntW-1:0] FullCnt =
    sdbm_pkg::QueueCntW'(sdbm_pkg::QueueDepth);

  assign stat_o.full      = (cnt_q == FullCnt);
  assign stat_o.not_empty = (cnt_q != '0);
  assign do_push          = push_i && !stat_o.full;
  assign do_pop           = pop_i && stat_o.not_empty;
  assign pop_data_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: design/sdbm_front.sv
module sdbm_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [sdbm_pkg::CharW-1:0]   s_axis_tdata_i,
  input  sdbm_pkg::q_stat_t            q_stat_i,
  output logic                         push_o,
  output sdbm_pkg::hash_t              push_data_o
);

  sdbm_pkg::hash_t acc_q, acc_d;
  sdbm_pkg::hash_t char_ext;
  logic            accept;
  logic            key_end;

  assign s_axis_tready_o = !q_stat_i.full;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign key_end         = (s_axis_tdata_i == sdbm_pkg::KeyEnd);

  // Key bytes are treated as signed characters.
  assign char_ext = {{(sdbm_pkg::HashW - sdbm_pkg::CharW){s_axis_tdata_i[sdbm_pkg::CharW-1]}},
                     s_axis_tdata_i};

  assign push_o      = accept && key_end;
  assign push_data_o = acc_q;

  always_comb begin
    acc_d = acc_q;
    if (accept) begin
      if (key_end) begin
        acc_d = '0;
      end else begin
        acc_d = char_ext + (acc_q << 6) + (acc_q << 16) - acc_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

endmodule

// File: design/sdbm_back.sv
module sdbm_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sdbm_pkg::bucket_t   bucket_count_i,
  input  sdbm_pkg::q_stat_t   q_stat_i,
  input  sdbm_pkg::hash_t     pop_data_i,
  output logic                pop_o,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output sdbm_pkg::bucket_t   m_axis_tdata_o
);

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } state_e;

  localparam logic [sdbm_pkg::DivCntW-1:0] LastStep =
    sdbm_pkg::DivCntW'(sdbm_pkg::HashW - 1);

  state_e                          state_q;
  logic [sdbm_pkg::DivCntW-1:0]    cnt_q;
  sdbm_pkg::hash_t                 dividend_q;
  sdbm_pkg::bucket_t               divisor_q;
  sdbm_pkg::bucket_t               rem_q, rem_d;
  sdbm_pkg::bucket_t               out_data_q;
  logic                            out_valid_q;
  logic [sdbm_pkg::BucketW:0]      rem_ext;
  logic [sdbm_pkg::BucketW:0]      rem_diff;
  logic                            last_step;
  logic                            step_en;

  assign pop_o           = (state_q == ST_IDLE) && q_stat_i.not_empty;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // One restoring division step per cycle unless stalled, hash MSB first.
  assign rem_ext  = {rem_q, dividend_q[sdbm_pkg::HashW-1]};
  assign rem_diff = rem_ext - {1'b0, divisor_q};
  assign rem_d    = (rem_ext >= {1'b0, divisor_q}) ? rem_diff[sdbm_pkg::BucketW-1:0]
                                                    : rem_ext[sdbm_pkg::BucketW-1:0];

  assign last_step = (cnt_q == LastStep);
  // The final step waits until the output register is free.
  assign step_en   = !(last_step && out_valid_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      dividend_q  <= '0;
      divisor_q   <= '0;
      rem_q       <= '0;
      out_data_q  <= '0;
    end else begin
      if (out_valid_q && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (q_stat_i.not_empty) begin
            dividend_q <= pop_data_i;
            divisor_q  <= bucket_count_i;
            rem_q      <= '0;
            cnt_q      <= '0;
            state_q    <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (step_en) begin
            dividend_q <= dividend_q << 1;
            rem_q      <= rem_d;
            cnt_q      <= cnt_q + 1'b1;
            if (last_step) begin
              out_data_q  <= (divisor_q == '0) ? '0 : rem_d;
              out_valid_q <= 1'b1;
              state_q     <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: design/sdbm_hash_bucket_select_top.sv
// Bucket selector with the sdbm string hash. Key bytes arrive one word per
// cycle on the slave stream while the queue is not full; each nonzero byte,
// taken as a signed character, is folded into a 64-bit hash in the same cycle,
// so a key of n bytes is taken as n + 1 bytes, its terminating zero byte
// included. The zero byte hands the finished hash to a two-entry queue and
// clears the hash for the next key. A back end reduces each queued hash modulo
// bucket_count with a restoring divider that retires one hash bit per cycle,
// its final step waiting while the output register is full. When idle, the
// back end pulls a hash from the queue, then runs 64 division steps; it takes
// no new hash before it is through with the last one. A bucket_count of
// zero yields bucket 0. Write bucket_count only while no key is in flight.
`include "assert_macros.svh"

module sdbm_hash_bucket_select_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sdbm_pkg::BucketW-1:0]   cfg_data_i,      // [15:0] bucket_count
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [sdbm_pkg::CharW-1:0]     s_axis_tdata_i,  // [7:0] char_code
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [sdbm_pkg::BucketW-1:0]   m_axis_tdata_o   // [15:0] bucket_index
);

  sdbm_pkg::bucket_t bucket_count_q;
  sdbm_pkg::q_stat_t q_stat;
  sdbm_pkg::hash_t   push_data;
  sdbm_pkg::hash_t   pop_data;
  logic              push;
  logic              pop;
  logic              bucket_bad;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_count_q <= sdbm_pkg::BucketW'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      bucket_count_q <= cfg_data_i;
    end
  end

  sdbm_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .q_stat_i        (q_stat),
    .push_o          (push),
    .push_data_o     (push_data)
  );

  sdbm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (q_stat)
  );

  sdbm_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .bucket_count_i  (bucket_count_q),
    .q_stat_i        (q_stat),
    .pop_data_i      (pop_data),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  assign bucket_bad = m_axis_tvalid_o && (bucket_count_q != '0) &&
                      (m_axis_tdata_o >= bucket_count_q);

  `SDBM_ASSERT_NEVER(a_no_queue_overflow, push && q_stat.full, "push into a full queue")
  `SDBM_ASSERT_NEVER(a_no_queue_underflow, pop && !q_stat.not_empty, "pop from an empty queue")
  `SDBM_ASSERT_NEVER(a_bucket_in_range, bucket_bad, "bucket index not below bucket count")

endmodule
